### hdl/least_loaded_row_contiguous_allocator_core_macros.svh
// Assertion helpers for the allocator checker.
`ifndef LEAST_LOADED_ROW_CONTIGUOUS_ALLOCATOR_CORE_MACROS_SVH
`define LEAST_LOADED_ROW_CONTIGUOUS_ALLOCATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LLRCA_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LLRCA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/llrca_pkg.sv
`timescale 1ns / 1ps
package llrca_pkg;

    // field widths
    localparam int ROW_W      = 4;
    localparam int SLOT_W     = 7;
    localparam int SIZE_W     = 8;
    localparam int WGT_W      = 10;
    localparam int LOAD_W     = 18;
    localparam int SUM_W      = 22;
    localparam int TOTAL_W    = 21;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // saturation limits
    localparam logic [LOAD_W-1:0]  LOAD_MAX  = '1;
    localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // word kinds carried on tuser
    localparam logic FUNC_MARK  = 1'b0;
    localparam logic FUNC_PLACE = 1'b1;

    // memory commands from the sequencer to the store
    typedef struct packed {
        logic rd;
        logic slot_wr;
        logic load_wr;
    } llrca_mem_cmd_t;

endpackage

### hdl/llrca_store.sv
`timescale 1ns / 1ps
module llrca_store
    import llrca_pkg::*;
#(
    parameter int ROWS  = 16,
    parameter int SLOTS = 128,
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  llrca_mem_cmd_t    cmd,
    input  logic [RW-1:0]     raddr,
    input  logic [RW-1:0]     waddr,
    input  logic [SLOTS-1:0]  slot_wdata,
    input  logic [LOAD_W-1:0] load_wdata,
    output logic [SLOTS-1:0]  slot_rdata,
    output logic [LOAD_W-1:0] load_rdata
);

    logic [SLOTS-1:0]  slot_mem [ROWS];
    logic [LOAD_W-1:0] load_mem [ROWS];

    logic [SLOTS-1:0]  slot_q_reg;
    logic [LOAD_W-1:0] load_q_reg;
    logic [ROWS-1:0]   slot_vld_reg;
    logic [ROWS-1:0]   load_vld_reg;
    logic              slot_qv_reg;
    logic              load_qv_reg;

    // row memories, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            slot_q_reg <= slot_mem[raddr];
            load_q_reg <= load_mem[raddr];
        end
        if (cmd.slot_wr)
            slot_mem[waddr] <= slot_wdata;
        if (cmd.load_wr)
            load_mem[waddr] <= load_wdata;
    end

    // per-row written flags; an unwritten row reads as free / zero load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg <= '0;
            load_vld_reg <= '0;
            slot_qv_reg  <= 1'b0;
            load_qv_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.rd)
            begin
                slot_qv_reg <= slot_vld_reg[raddr];
                load_qv_reg <= load_vld_reg[raddr];
            end
            if (cmd.slot_wr)
                slot_vld_reg[waddr] <= 1'b1;
            if (cmd.load_wr)
                load_vld_reg[waddr] <= 1'b1;
        end
    end

    assign slot_rdata = slot_qv_reg ? slot_q_reg : '0;
    assign load_rdata = load_qv_reg ? load_q_reg : '0;

endmodule

### hdl/llrca_fit.sv
`timescale 1ns / 1ps
module llrca_fit
    import llrca_pkg::*;
#(
    parameter int SLOTS = 128
)
(
    input  logic [SLOTS-1:0]  free,
    input  logic [SIZE_W-1:0] size,
    output logic [SLOTS-1:0]  hit
);

    // hit[i] set when the free run ending at slot i is at least size long.
    // pw holds runs of 2^j ending at each slot; acc grows by one power of two
    // per set bit of size, always by a fixed shift.
    always_comb
    begin : run_scan
        logic [SLOTS-1:0] pw;
        logic [SLOTS-1:0] acc;
        logic             started;
        pw      = free;
        acc     = '0;
        started = 1'b0;
        for (int j = 0; j < SIZE_W; j++)
        begin
            if (size[j])
            begin
                if (started)
                    acc = pw & (acc << (1 << j));
                else
                    acc = pw;
                started = 1'b1;
            end
            pw = pw & (pw << (1 << j));
        end
        hit = acc;
    end

endmodule

### hdl/least_loaded_row_contiguous_allocator_core.sv
`timescale 1ns / 1ps
// Least-loaded-row contiguous allocator.
// Input channel s_axis: tuser = 0 blocks one slot (row, slot in tdata),
// tuser = 1 asks for item_size contiguous free slots carrying item_weight.
// Output channel m_axis: one word per input word; tuser = placed, tdata gives
// the chosen row, the first slot of the run and the saturated weight total.
// Steps: a mark reads the row, then writes it back with the slot set; a place
// first sweeps the load memory for the least load, then checks one row of
// slot memory per cycle, then works out the run and writes slots and load.
// Throughput is one word at a time: s_axis_tready is high only while idle,
// so the sweeps of a place word are paced by the single read port of the
// row memories. The result sits in an output register, so a new input
// word is taken while an earlier result waits; the block stalls before
// loading a new result if the receiver has not taken the previous one.
// Reset: asynchronous, active low. All slots read free and all loads zero
// straight after reset through per-row written flags; no clearing pass.
module least_loaded_row_contiguous_allocator_core
    import llrca_pkg::*;
#(
    parameter int ROWS  = 16,
    parameter int SLOTS = 128
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [3:0] block_row, [10:4] block_slot, [18:11] item_size,
    // [28:19] item_weight, [31:29] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] placed_row, [10:4] placed_slot, [31:11] total_weight
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] placed
    output logic                  m_axis_tuser
);

    localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(ROWS + 1);
    localparam int ZW = SW + 1;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_MARK_RD = 8'b0000_0010,
        S_MARK_WR = 8'b0000_0100,
        S_MIN     = 8'b0000_1000,
        S_FIT     = 8'b0001_0000,
        S_PLACE   = 8'b0010_0000,
        S_WRITE   = 8'b0100_0000,
        S_OUT     = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 func_reg;
    logic [ROW_W-1:0]     brow_reg;
    logic [SLOT_W-1:0]    bslot_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [WGT_W-1:0]     wgt_reg;
    logic [LOAD_W-1:0]    min_reg;
    logic [RW-1:0]        hit_row_reg;
    logic [SLOTS-1:0]     hit_vec_reg;
    logic [SLOTS-1:0]     row_data_reg;
    logic [LOAD_W-1:0]    hit_load_reg;
    logic [SW-1:0]        start_reg;
    logic [SW-1:0]        end_reg;
    logic                 placed_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 out_valid_reg;
    logic                 out_user_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // incoming word fields
    logic [ROW_W-1:0]     in_row;
    logic [SLOT_W-1:0]    in_slot;
    logic [SIZE_W-1:0]    in_size;
    logic [WGT_W-1:0]     in_wgt;
    logic                 in_acc;
    logic                 mark_ok;
    logic                 size_ok;

    // memory side
    llrca_mem_cmd_t       mem_cmd;
    logic [RW-1:0]        mem_raddr;
    logic [RW-1:0]        mem_waddr;
    logic [SLOTS-1:0]     slot_wdata;
    logic [LOAD_W-1:0]    load_wdata;
    logic [SLOTS-1:0]     slot_rdata;
    logic [LOAD_W-1:0]    load_rdata;

    logic [SLOTS-1:0]     fit_hit;
    logic                 row_fits;
    logic                 data_here;
    logic                 sweep_end;
    logic [SW-1:0]        end_idx;
    logic [ZW-1:0]        start_calc;
    logic [SLOTS-1:0]     run_mask;
    logic [LOAD_W:0]      load_sum;
    logic [SUM_W:0]       wsum;
    logic                 out_free;
    logic [TOTAL_W-1:0]   total_sat;
    logic [ROW_W-1:0]     res_row;
    logic [SLOT_W-1:0]    res_slot;

    assign in_row  = s_axis_tdata[ROW_W-1:0];
    assign in_slot = s_axis_tdata[ROW_W +: SLOT_W];
    assign in_size = s_axis_tdata[ROW_W+SLOT_W +: SIZE_W];
    assign in_wgt  = s_axis_tdata[ROW_W+SLOT_W+SIZE_W +: WGT_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign mark_ok       = (int'(in_row) < ROWS) && (int'(in_slot) < SLOTS);
    assign size_ok       = (in_size != '0) && (int'(in_size) <= SLOTS);

    assign data_here = (cnt_reg != '0);
    assign sweep_end = (cnt_reg == CW'(ROWS));
    assign row_fits  = (load_rdata == min_reg) && (|fit_hit);
    assign out_free  = !out_valid_reg || m_axis_tready;

    llrca_store #(
        .ROWS  (ROWS),
        .SLOTS (SLOTS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (mem_cmd),
        .raddr      (mem_raddr),
        .waddr      (mem_waddr),
        .slot_wdata (slot_wdata),
        .load_wdata (load_wdata),
        .slot_rdata (slot_rdata),
        .load_rdata (load_rdata)
    );

    llrca_fit #(
        .SLOTS (SLOTS)
    ) u_fit (
        .free (~slot_rdata),
        .size (size_reg),
        .hit  (fit_hit)
    );

    // end of the first fitting run
    always_comb
    begin
        end_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
                end_idx = SW'(i);
        end
    end

    assign start_calc = ZW'(end_idx) + ZW'(1) - ZW'(size_reg);

    // slots from start to end inclusive
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            run_mask[i] = (SW'(i) >= start_reg) && (SW'(i) <= end_reg);
    end

    // saturating adds
    assign load_sum = {1'b0, hit_load_reg} + (LOAD_W+1)'(wgt_reg);
    assign wsum     = {1'b0, sum_reg} + (SUM_W+1)'(wgt_reg);

    // memory commands
    always_comb
    begin
        mem_cmd    = '0;
        mem_raddr  = RW'(cnt_reg);
        mem_waddr  = hit_row_reg;
        slot_wdata = row_data_reg | run_mask;
        load_wdata = load_sum[LOAD_W] ? LOAD_MAX : load_sum[LOAD_W-1:0];
        unique case (state_reg)
            S_MARK_RD:
            begin
                mem_cmd.rd = 1'b1;
                mem_raddr  = RW'(brow_reg);
            end
            S_MARK_WR:
            begin
                mem_cmd.slot_wr = 1'b1;
                mem_waddr       = RW'(brow_reg);
                slot_wdata      = slot_rdata | (SLOTS'(1) << bslot_reg);
            end
            S_MIN, S_FIT:
                mem_cmd.rd = !sweep_end;
            S_WRITE:
            begin
                mem_cmd.slot_wr = 1'b1;
                mem_cmd.load_wr = 1'b1;
            end
            default:
                mem_cmd = '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_acc)
                begin
                    if (s_axis_tuser == FUNC_MARK)
                        state_next = mark_ok ? S_MARK_RD : S_OUT;
                    else
                        state_next = size_ok ? S_MIN : S_OUT;
                end
            end
            S_MARK_RD:
                state_next = S_MARK_WR;
            S_MARK_WR:
                state_next = S_OUT;
            S_MIN:
            begin
                if (sweep_end)
                begin
                    cnt_next   = '0;
                    state_next = S_FIT;
                end
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_FIT:
            begin
                if (data_here && row_fits)
                    state_next = S_PLACE;
                else if (sweep_end)
                    state_next = S_OUT;
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            S_PLACE:
                state_next = S_WRITE;
            S_WRITE:
                state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            placed_reg    <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (in_acc)
                placed_reg <= 1'b0;
            else if (state_reg == S_WRITE)
                placed_reg <= 1'b1;
            if (state_reg == S_WRITE)
                sum_reg <= wsum[SUM_W] ? SUM_MAX : wsum[SUM_W-1:0];
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result fields
    assign total_sat = (sum_reg > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_reg[TOTAL_W-1:0];
    assign res_row   = placed_reg ? ROW_W'(hit_row_reg) : '0;
    assign res_slot  = placed_reg ? SLOT_W'(start_reg) : '0;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg  <= s_axis_tuser;
            brow_reg  <= in_row;
            bslot_reg <= in_slot;
            size_reg  <= in_size;
            wgt_reg   <= in_wgt;
        end
        // least load over all rows
        if (state_reg == S_MIN && data_here)
        begin
            if (cnt_reg == CW'(1) || load_rdata < min_reg)
                min_reg <= load_rdata;
        end
        // capture the first least-loaded row with room
        if (state_reg == S_FIT && data_here && row_fits)
        begin
            hit_row_reg  <= RW'(cnt_reg - CW'(1));
            hit_vec_reg  <= fit_hit;
            row_data_reg <= slot_rdata;
            hit_load_reg <= load_rdata;
        end
        if (state_reg == S_PLACE)
        begin
            end_reg   <= end_idx;
            start_reg <= SW'(start_calc);
        end
        if (state_reg == S_OUT && out_free)
        begin
            out_user_reg <= placed_reg && (func_reg == FUNC_PLACE);
            out_data_reg <= {total_sat, res_slot, res_row};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### hdl/llrca_checker.sv
`timescale 1ns / 1ps
`include "least_loaded_row_contiguous_allocator_core_macros.svh"
module llrca_checker
    import llrca_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    // a stalled result word holds
    `LLRCA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")

    // one word in flight: input closes straight after acceptance
    `LLRCA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted again before the result was formed")

    // a word that was not placed carries zero row and slot
    `LLRCA_ASSERT_SAME(a_unplaced_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[SLOT_W+ROW_W-1:0] == '0, "unplaced word has non-zero row or slot")

endmodule

bind least_loaded_row_contiguous_allocator_core llrca_checker u_llrca_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
